@@ sv/cbrb_pkg.sv @@
`timescale 1ns / 1ps

package cbrb_pkg;

  localparam int OpW     = 2;
  localparam int ByteW   = 8;
  localparam int LenW    = 10;
  localparam int CountW  = 7;
  localparam int StatusW = 2;
  localparam int FillW   = 8;

  typedef enum logic [OpW-1:0] {
    OP_APPEND  = 2'd0,
    OP_CONSUME = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_TAKE    = 2'd3
  } op_t;

  localparam logic [StatusW-1:0] STS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STS_REJECT   = 2'd1;
  localparam logic [StatusW-1:0] STS_OVERFLOW = 2'd2;

endpackage

@@ sv/chunked_byte_ring_buffer.sv @@
`timescale 1ns / 1ps

// Byte ring buffer that admits whole chunks. Each request is taken when start is high and
// busy is low, and busy then stays high until the request's last result has been issued.
// Append, clear, take and rejected or zero-length consume requests give one result, registered
// from the execute state, and are busy only in that state. A consume of n bytes is busy through
// the execute and read states and gives its n results one byte per cycle, paced by
// the single read port of the byte store. Every result is shown for exactly one cycle with
// out_strobe high and cannot be held off, so the receiver must take it in that cycle.
module chunked_byte_ring_buffer #(
  parameter int CAPACITY    = 256,
  parameter int MAX_CONSUME = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [cbrb_pkg::OpW-1:0]          in_op,
  input  logic [cbrb_pkg::ByteW-1:0]        in_data_byte,
  input  logic                              in_first_of_chunk,
  input  logic [cbrb_pkg::LenW-1:0]         in_chunk_length,
  input  logic [cbrb_pkg::CountW-1:0]       in_consume_count,
  output logic                              out_strobe,
  output logic [cbrb_pkg::StatusW-1:0]      out_status,
  output logic [cbrb_pkg::ByteW-1:0]        out_read_byte,
  output logic                              out_last,
  output logic [cbrb_pkg::FillW-1:0]        out_fill_level,
  output logic                              out_overflow_seen
);

  localparam int PW = $clog2(CAPACITY);
  localparam int SW = ((PW > cbrb_pkg::LenW) ? PW : cbrb_pkg::LenW) + 1;
  localparam logic [PW-1:0] PtrLast = PW'(CAPACITY - 1);
  localparam logic [SW-1:0] CapWide = SW'(CAPACITY);
  localparam logic [cbrb_pkg::CountW-1:0] MaxCnt = cbrb_pkg::CountW'(MAX_CONSUME);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    advance = (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  logic [cbrb_pkg::ByteW-1:0] mem [CAPACITY];
  logic [cbrb_pkg::ByteW-1:0] rd_q_r;

  state_t                          state_r, state_nxt;
  cbrb_pkg::op_t                   op_r, op_nxt;
  logic [cbrb_pkg::ByteW-1:0]      byte_r, byte_nxt;
  logic                            first_r, first_nxt;
  logic [cbrb_pkg::LenW-1:0]       len_r, len_nxt;
  logic [cbrb_pkg::CountW-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]                   rp_r, rp_nxt;
  logic [PW-1:0]                   wp_r, wp_nxt;
  logic [PW-1:0]                   sp_r, sp_nxt;
  logic [PW-1:0]                   fill_r, fill_nxt;
  logic [cbrb_pkg::LenW-1:0]       rem_r, rem_nxt;
  logic [cbrb_pkg::LenW-1:0]       clen_r, clen_nxt;
  logic                            adm_r, adm_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            strobe_r, strobe_nxt;
  logic [cbrb_pkg::StatusW-1:0]    status_r, status_nxt;
  logic                            last_r, last_nxt;
  logic                            sel_r, sel_nxt;
  logic [cbrb_pkg::FillW-1:0]      fill_out_r, fill_out_nxt;
  logic                            ovf_out_r, ovf_out_nxt;

  logic                            mem_we;
  logic [PW-1:0]                   mem_waddr;
  logic                            mem_re;

  logic [SW-1:0]                   fill_w;
  logic [SW-1:0]                   len_w;
  logic [PW-1:0]                   base_p;
  logic [cbrb_pkg::LenW-1:0]       base_rem;
  logic [cbrb_pkg::LenW-1:0]       base_clen;
  logic [PW-1:0]                   sp_adv;

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_read_byte  = sel_r ? rd_q_r : '0;
  assign out_last       = last_r;
  assign out_fill_level = fill_out_r;
  assign out_overflow_seen = ovf_out_r;

  assign fill_w = SW'(fill_r);
  assign len_w  = SW'(len_r);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    byte_nxt     = byte_r;
    first_nxt    = first_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    sp_nxt       = sp_r;
    fill_nxt     = fill_r;
    rem_nxt      = rem_r;
    clen_nxt     = clen_r;
    adm_nxt      = adm_r;
    ovf_nxt      = ovf_r;
    strobe_nxt   = 1'b0;
    status_nxt   = cbrb_pkg::STS_OK;
    last_nxt     = 1'b1;
    sel_nxt      = 1'b0;
    fill_out_nxt = fill_out_r;
    ovf_out_nxt  = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = sp_r;
    mem_re       = 1'b0;
    base_p       = first_r ? wp_r : sp_r;
    base_rem     = first_r ? len_r : rem_r;
    base_clen    = first_r ? len_r : clen_r;
    sp_adv       = advance(base_p);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = cbrb_pkg::op_t'(in_op);
          byte_nxt  = in_data_byte;
          first_nxt = in_first_of_chunk;
          len_nxt   = in_chunk_length;
          cnt_nxt   = in_consume_count;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
        case (op_r)
          cbrb_pkg::OP_APPEND: begin
            if (first_r) begin
              sp_nxt  = wp_r;
              adm_nxt = 1'b0;
              rem_nxt = '0;
            end
            if (first_r && (len_r == '0 || len_w >= CapWide)) begin
              status_nxt = cbrb_pkg::STS_REJECT;
            end else if (first_r && (len_w + fill_w >= CapWide)) begin
              status_nxt = cbrb_pkg::STS_OVERFLOW;
              ovf_nxt    = 1'b1;
              rem_nxt    = len_r - 1'b1;
            end else if (!first_r && rem_r == '0) begin
              status_nxt = cbrb_pkg::STS_REJECT;
            end else if (!first_r && !adm_r) begin
              status_nxt = cbrb_pkg::STS_REJECT;
              rem_nxt    = rem_r - 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = base_p;
              sp_nxt    = sp_adv;
              rem_nxt   = base_rem - 1'b1;
              clen_nxt  = base_clen;
              adm_nxt   = 1'b1;
              if (base_rem == 10'd1) begin
                wp_nxt   = sp_adv;
                adm_nxt  = 1'b0;
                fill_nxt = fill_r + PW'(base_clen);
              end
            end
            fill_out_nxt = cbrb_pkg::FillW'(SW'(fill_nxt));
          end
          cbrb_pkg::OP_CONSUME: begin
            if (cnt_r > MaxCnt || SW'(cnt_r) > fill_w) begin
              status_nxt   = cbrb_pkg::STS_REJECT;
              fill_out_nxt = cbrb_pkg::FillW'(fill_w);
            end else if (cnt_r == '0) begin
              fill_out_nxt = cbrb_pkg::FillW'(fill_w);
            end else begin
              strobe_nxt   = 1'b0;
              fill_nxt     = fill_r - PW'(cnt_r);
              fill_out_nxt = cbrb_pkg::FillW'(fill_w - SW'(cnt_r));
              state_nxt    = ST_READ;
            end
          end
          cbrb_pkg::OP_CLEAR: begin
            rp_nxt       = wp_r;
            fill_nxt     = '0;
            ovf_nxt      = 1'b0;
            fill_out_nxt = '0;
          end
          cbrb_pkg::OP_TAKE: begin
            ovf_out_nxt  = ovf_r;
            ovf_nxt      = 1'b0;
            fill_out_nxt = cbrb_pkg::FillW'(fill_w);
          end
          default: begin
            status_nxt = cbrb_pkg::STS_REJECT;
          end
        endcase
      end
      ST_READ: begin
        mem_re     = 1'b1;
        rp_nxt     = advance(rp_r);
        cnt_nxt    = cnt_r - 1'b1;
        strobe_nxt = 1'b1;
        sel_nxt    = 1'b1;
        last_nxt   = (cnt_r == 7'd1);
        if (cnt_r == 7'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      op_r       <= cbrb_pkg::OP_APPEND;
      byte_r     <= '0;
      first_r    <= 1'b0;
      len_r      <= '0;
      cnt_r      <= '0;
      rp_r       <= '0;
      wp_r       <= '0;
      sp_r       <= '0;
      fill_r     <= '0;
      rem_r      <= '0;
      clen_r     <= '0;
      adm_r      <= 1'b0;
      ovf_r      <= 1'b0;
      strobe_r   <= 1'b0;
      status_r   <= cbrb_pkg::STS_OK;
      last_r     <= 1'b0;
      sel_r      <= 1'b0;
      fill_out_r <= '0;
      ovf_out_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      op_r       <= op_nxt;
      byte_r     <= byte_nxt;
      first_r    <= first_nxt;
      len_r      <= len_nxt;
      cnt_r      <= cnt_nxt;
      rp_r       <= rp_nxt;
      wp_r       <= wp_nxt;
      sp_r       <= sp_nxt;
      fill_r     <= fill_nxt;
      rem_r      <= rem_nxt;
      clen_r     <= clen_nxt;
      adm_r      <= adm_nxt;
      ovf_r      <= ovf_nxt;
      strobe_r   <= strobe_nxt;
      status_r   <= status_nxt;
      last_r     <= last_nxt;
      sel_r      <= sel_nxt;
      fill_out_r <= fill_out_nxt;
      ovf_out_r  <= ovf_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= byte_r;
    end
    if (mem_re) begin
      rd_q_r <= mem[rp_r];
    end
  end

endmodule
